// ===== hw/rtl/stunbr_pkg.sv =====
// Shared constants, codes and types for the STUN binding response parser.
// Used by the parser core, result register, top level and checker.
package stunbr_pkg;

	localparam int MAX_DATAGRAM_BYTES = 2048;
	// Byte position must be able to hold the maximum itself.
	localparam int POS_W = $clog2(MAX_DATAGRAM_BYTES + 1);
	localparam int HEADER_BYTES = 20;

	localparam logic [31:0] STUN_COOKIE = 32'h2112A442;
	localparam logic [15:0] TYPE_BINDING_RESPONSE = 16'h0101;
	localparam logic [15:0] ATTR_XOR_MAPPED = 16'h0020;
	localparam logic [15:0] ATTR_MAPPED = 16'h0001;
	localparam logic [7:0] FAMILY_IPV4 = 8'h01;

	localparam logic [2:0] FAIL_NONE = 3'd0;
	localparam logic [2:0] FAIL_SHORT = 3'd1;
	localparam logic [2:0] FAIL_TYPE = 3'd2;
	localparam logic [2:0] FAIL_COOKIE = 3'd3;
	localparam logic [2:0] FAIL_TXN = 3'd4;
	localparam logic [2:0] FAIL_NO_ADDR = 3'd5;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TXN_UPPER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TXN_LOWER = 1'd1;

	typedef struct packed {
		logic success;
		logic [2:0] fail_reason;
		logic from_xor_attribute;
		logic [31:0] mapped_address;
		logic [15:0] mapped_port;
	} res_t;

endpackage

// ===== hw/rtl/stunbr_in_reg.sv =====
// Input register stage: holds one datagram word until the parser takes it.
// Depends on nothing but the clock and reset.
module stunbr_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       last_s1
);

	// A new word may enter when the stage is empty or is being emptied.
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

endmodule

// ===== hw/rtl/stunbr_parser.sv =====
// Parser core: transaction ID registers, header checks and attribute walk.
// One word per cycle unless a last word stalls; result formed on it; uses stunbr_pkg.
module stunbr_parser
	import stunbr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 valid_s1,
	input  logic [7:0]           byte_s1,
	input  logic                 last_s1,
	input  logic                 out_free,
	output logic                 take,
	output logic                 res_push,
	output res_t                 res
);

	localparam logic [2:0] PH_MSG_HEADER = 3'd0;
	localparam logic [2:0] PH_ATTR_HEAD = 3'd1;
	localparam logic [2:0] PH_VALUE = 3'd2;
	localparam logic [2:0] PH_PAD = 3'd3;
	localparam logic [2:0] PH_DONE = 3'd4;

	logic [31:0] txn_upper_q;
	logic [63:0] txn_lower_q;

	logic [POS_W-1:0] pos_q, pos_n;
	logic [15:0] mtype_q, mtype_n;
	logic [15:0] mlen_q, mlen_n;
	logic [2:0] herr_q, herr_n;
	logic [2:0] phase_q, phase_n;
	logic [15:0] atype_q, atype_n;
	logic [15:0] arem_q, arem_n;
	logic [10:0] aoff_q, aoff_n;
	logic [55:0] pend_q, pend_n;
	logic found_q, found_n;
	logic fxor_q, fxor_n;
	logic [47:0] ep_q, ep_n;

	logic [127:0] hdr_exp;
	logic [3:0] exp_idx;
	logic [7:0] exp_byte;
	logic [15:0] mtype_shift;
	logic [16:0] attr_end;
	logic [16:0] msg_end;
	logic [15:0] arem_dec;
	logic [10:0] aoff_inc;
	logic [1:0] pad;
	logic [2:0] reason;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			txn_upper_q <= '0;
			txn_lower_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TXN_UPPER: txn_upper_q <= cfg_data[31:0];
				REG_TXN_LOWER: txn_lower_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A word carrying the last mark needs room in the result register.
	assign take = valid_s1 && (!last_s1 || out_free);
	assign res_push = take && last_s1;

	// Header bytes 4 to 19 are compared against cookie then transaction ID.
	assign hdr_exp = {STUN_COOKIE, txn_upper_q, txn_lower_q};
	assign exp_idx = pos_q[3:0] - 4'd4;
	assign exp_byte = hdr_exp[{4'd15 - exp_idx, 3'b000} +: 8];
	assign mtype_shift = {mtype_q[7:0], byte_s1};
	assign attr_end = 17'(pos_q) + 17'd4;
	assign msg_end = {1'b0, mlen_q} + 17'(HEADER_BYTES);
	assign arem_dec = arem_q - 16'd1;
	assign aoff_inc = aoff_q + 11'd1;
	assign pad = 2'd0 - aoff_inc[1:0];

	always_comb begin
		pos_n = pos_q;
		mtype_n = mtype_q;
		mlen_n = mlen_q;
		herr_n = herr_q;
		phase_n = phase_q;
		atype_n = atype_q;
		arem_n = arem_q;
		aoff_n = aoff_q;
		pend_n = pend_q;
		found_n = found_q;
		fxor_n = fxor_q;
		ep_n = ep_q;
		if (pos_q < POS_W'(MAX_DATAGRAM_BYTES)) begin
			pos_n = pos_q + POS_W'(1);
			case (phase_q)
				PH_MSG_HEADER: begin
					if (pos_q < POS_W'(2)) begin
						mtype_n = mtype_shift;
						if (pos_q == POS_W'(1) && mtype_shift != TYPE_BINDING_RESPONSE &&
						    herr_q == FAIL_NONE)
							herr_n = FAIL_TYPE;
					end else if (pos_q < POS_W'(4)) begin
						mlen_n = {mlen_q[7:0], byte_s1};
					end else if (byte_s1 != exp_byte && herr_q == FAIL_NONE) begin
						herr_n = (pos_q < POS_W'(8)) ? FAIL_COOKIE : FAIL_TXN;
					end
					if (pos_q == POS_W'(HEADER_BYTES - 1)) begin
						phase_n = PH_ATTR_HEAD;
						aoff_n = '0;
					end
				end
				PH_ATTR_HEAD: begin
					if (aoff_q == 11'd0 && attr_end > msg_end) begin
						phase_n = PH_DONE;
					end else begin
						if (aoff_q < 11'd2)
							atype_n = {atype_q[7:0], byte_s1};
						else
							arem_n = {arem_q[7:0], byte_s1};
						if (aoff_q == 11'd3) begin
							aoff_n = '0;
							pend_n = '0;
							if (arem_n != 16'd0)
								phase_n = PH_VALUE;
						end else begin
							aoff_n = aoff_inc;
						end
					end
				end
				PH_VALUE: begin
					if (aoff_q >= 11'd1 && aoff_q <= 11'd7)
						pend_n = {pend_q[47:0], byte_s1};
					aoff_n = aoff_inc;
					arem_n = arem_dec;
					if (arem_dec == 16'd0) begin
						// Whole value in: commit the candidate, then skip padding.
						if (aoff_inc >= 11'd8 && pend_n[55:48] == FAMILY_IPV4) begin
							if (atype_q == ATTR_XOR_MAPPED) begin
								ep_n = {pend_n[31:0] ^ STUN_COOKIE,
								        pend_n[47:32] ^ STUN_COOKIE[31:16]};
								found_n = 1'b1;
								fxor_n = 1'b1;
							end else if (atype_q == ATTR_MAPPED && !found_q) begin
								ep_n = {pend_n[31:0], pend_n[47:32]};
								found_n = 1'b1;
								fxor_n = 1'b0;
							end
						end
						aoff_n = '0;
						arem_n = {14'd0, pad};
						phase_n = (pad != 2'd0) ? PH_PAD : PH_ATTR_HEAD;
					end
				end
				PH_PAD: begin
					arem_n = arem_dec;
					if (arem_dec == 16'd0) begin
						phase_n = PH_ATTR_HEAD;
						aoff_n = '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		if (pos_n < POS_W'(HEADER_BYTES))
			reason = FAIL_SHORT;
		else if (herr_n != FAIL_NONE)
			reason = herr_n;
		else if (!found_n)
			reason = FAIL_NO_ADDR;
		else
			reason = FAIL_NONE;
		res.success = (reason == FAIL_NONE);
		res.fail_reason = reason;
		res.from_xor_attribute = res.success & fxor_n;
		res.mapped_address = res.success ? ep_n[47:16] : 32'd0;
		res.mapped_port = res.success ? ep_n[15:0] : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			mtype_q <= '0;
			mlen_q <= '0;
			herr_q <= FAIL_NONE;
			phase_q <= PH_MSG_HEADER;
			atype_q <= '0;
			arem_q <= '0;
			aoff_q <= '0;
			pend_q <= '0;
			found_q <= 1'b0;
			fxor_q <= 1'b0;
			ep_q <= '0;
		end else if (res_push) begin
			// The datagram has ended: start clean for the next one.
			pos_q <= '0;
			mtype_q <= '0;
			mlen_q <= '0;
			herr_q <= FAIL_NONE;
			phase_q <= PH_MSG_HEADER;
			atype_q <= '0;
			arem_q <= '0;
			aoff_q <= '0;
			pend_q <= '0;
			found_q <= 1'b0;
			fxor_q <= 1'b0;
			ep_q <= '0;
		end else if (take) begin
			pos_q <= pos_n;
			mtype_q <= mtype_n;
			mlen_q <= mlen_n;
			herr_q <= herr_n;
			phase_q <= phase_n;
			atype_q <= atype_n;
			arem_q <= arem_n;
			aoff_q <= aoff_n;
			pend_q <= pend_n;
			found_q <= found_n;
			fxor_q <= fxor_n;
			ep_q <= ep_n;
		end
	end

endmodule

// ===== hw/rtl/stunbr_out_reg.sv =====
// Result register: holds one result word until the consumer takes it.
// Uses the result type from stunbr_pkg.
module stunbr_out_reg
	import stunbr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  res_push,
	input  res_t  res,
	output logic  out_free,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  res_q
);

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_push) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push)
			res_q <= res;
	end

endmodule

// ===== hw/rtl/stun_binding_response_parser_top.sv =====
// A datagram's last byte goes through the input register; its result word is then registered
// in the result register. One byte per cycle unless a last byte stalls; one state update each.
// One result register parts the two sides: bytes keep flowing while a result waits, and only a
// further last byte stalls until that result word is taken.
// Top level: joins the input register, the parser core and the result register.
// Depends on stunbr_pkg, stunbr_in_reg, stunbr_parser and stunbr_out_reg.
module stun_binding_response_parser_top
	import stunbr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 success,
	output logic [2:0]           fail_reason,
	output logic                 from_xor_attribute,
	output logic [31:0]          mapped_address,
	output logic [15:0]          mapped_port
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;
	logic take;
	logic res_push;
	logic out_free;
	res_t res;
	res_t res_q;

	stunbr_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.last_s1  (last_s1)
	);

	stunbr_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.last_s1  (last_s1),
		.out_free (out_free),
		.take     (take),
		.res_push (res_push),
		.res      (res)
	);

	stunbr_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.out_free (out_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res_q    (res_q)
	);

	assign success = res_q.success;
	assign fail_reason = res_q.fail_reason;
	assign from_xor_attribute = res_q.from_xor_attribute;
	assign mapped_address = res_q.mapped_address;
	assign mapped_port = res_q.mapped_port;

endmodule

// ===== hw/rtl/stunbr_checker.sv =====
// Port-level checker for the parser top level, with its bind statement.
// Depends on stunbr_pkg for the failure codes.
module stunbr_checker
	import stunbr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        success,
	input logic [2:0]  fail_reason,
	input logic        from_xor_attribute,
	input logic [31:0] mapped_address,
	input logic [15:0] mapped_port
);

	// A stalled result word must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(success) &&
		$stable(fail_reason) && $stable(from_xor_attribute) &&
		$stable(mapped_address) && $stable(mapped_port))
		else $error("result word changed while stalled");

	a_success_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> success == (fail_reason == FAIL_NONE))
		else $error("success disagrees with failure reason");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !success |-> !from_xor_attribute && mapped_address == 32'd0 &&
		mapped_port == 16'd0)
		else $error("failed result carries an endpoint");

	a_reason_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fail_reason <= FAIL_NO_ADDR)
		else $error("failure reason out of range");

	// Register writes are never held off.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration write held off");

endmodule

bind stun_binding_response_parser_top stunbr_checker u_stunbr_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.cfg_ready         (cfg_ready),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.success           (success),
	.fail_reason       (fail_reason),
	.from_xor_attribute(from_xor_attribute),
	.mapped_address    (mapped_address),
	.mapped_port       (mapped_port)
);
